// File: rtl/core/dfaec_pkg.sv
// ----------------------------------------------------------------------------
// DFA equivalent-state counter package
// Operation codes, register indexes and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dfaec_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_FINAL = 2'd0;
  localparam logic [1:0] OP_TRANS = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_STATES  = 1'b0;
  localparam logic REG_SYMBOLS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [4:0] STATES_RST  = 5'd16;
  localparam logic [3:0] SYMBOLS_RST = 4'd8;

  // A transition entry is a present bit above a four-bit target.
  localparam int TR_W      = 5;
  localparam int TGT_W     = 4;
  localparam int CLASS_MAX = 31;

  typedef struct packed {
    logic clr_step;     // clear one transition entry after reset
    logic load_fin;     // write a finality flag
    logic load_tr;      // write a transition entry
    logic comp_start;   // open the initial marking sweep
    logic row_capture;  // take the row of state i into the row register
    logic pair_rd;      // pair table read address follows the target pair
    logic j_next;       // move to the next partner state
    logic a_clear;      // restart at symbol zero
    logic a_next;       // move to the next symbol
    logic mark;         // mark the current pair distinct
    logic row_write;    // write the row register back
    logic i_next;       // move to the next row
    logic sweep_next;   // open another propagation sweep
    logic cnt_start;    // open the class count scan
    logic cnt_acc;      // fold one row into the non-leader set
    logic tally_start;  // open the leader tally
    logic tally;        // count one leader
  } dfaec_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic j_end;
    logic row_bit;
    logic ev_hit;
    logic ev_need_d;
    logic d_hit;
    logic a_last;
    logic i_last;
    logic again;
  } dfaec_sts_t;

endpackage

// File: rtl/core/dfa_equivalent_state_counter.sv
// ----------------------------------------------------------------------------
// Load words: one load word per cycle while busy is low. A count with N
// states, M symbols and P = N*(N-1)/2 pairs in use runs up to P+2 sweeps,
// each a symbol loop over the pairs with one table read per step, then a
// class tally. Reset: busy stays high through the clearing pass. Load words
// are not taken while busy is high.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// DFA equivalent-state counter
// Holds an automaton's finality flags and transitions and counts its classes
// of equivalent states by table filling.
// ----------------------------------------------------------------------------
module dfa_equivalent_state_counter #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [3:0]  state_index_i,
  input  logic [2:0]  symbol_index_i,
  input  logic [3:0]  target_state_i,
  input  logic        has_target_i,
  input  logic        final_mark_i,
  output logic        done_o,
  output logic [4:0]  class_count_o
);
  import dfaec_pkg::*;

  logic [4:0] state_count_q;
  logic [3:0] symbol_count_q;
  logic       cfg_we;
  dfaec_cmd_t cmd;
  dfaec_sts_t sts;

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q  <= STATES_RST;
      symbol_count_q <= SYMBOLS_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_STATES) begin
        state_count_q <= pwdata[4:0];
      end else begin
        symbol_count_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SYMBOLS) ? {28'd0, symbol_count_q} : {27'd0, state_count_q};

  dfaec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  dfaec_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .state_count_i  (state_count_q),
    .symbol_count_i (symbol_count_q),
    .state_index_i  (state_index_i),
    .symbol_index_i (symbol_index_i),
    .target_state_i (target_state_i),
    .has_target_i   (has_target_i),
    .final_mark_i   (final_mark_i),
    .class_count_o  (class_count_o)
  );

endmodule

// File: rtl/core/dfaec_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfaec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dfaec_dp.sv
// ----------------------------------------------------------------------------
// DFA equivalent-state counter datapath
// Transition and pair tables, finality flags, sweep counters and the class
// tally. Acts on the commands of the controller and reports status.
// ----------------------------------------------------------------------------
module dfaec_dp #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dfaec_pkg::dfaec_cmd_t cmd_i,
  output dfaec_pkg::dfaec_sts_t sts_o,
  input  logic [4:0]           state_count_i,
  input  logic [3:0]           symbol_count_i,
  input  logic [3:0]           state_index_i,
  input  logic [2:0]           symbol_index_i,
  input  logic [3:0]           target_state_i,
  input  logic                 has_target_i,
  input  logic                 final_mark_i,
  output logic [4:0]           class_count_o
);
  import dfaec_pkg::*;

  localparam int SW     = $clog2(MAX_STATES);
  localparam int NW     = $clog2(MAX_STATES + 1);
  localparam int AW     = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int YW     = $clog2(MAX_SYMBOLS + 1);
  localparam int TDEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int TAW    = $clog2(TDEPTH);

  logic [NW-1:0]         ns;
  logic [YW-1:0]         nsym;
  logic [TAW-1:0]        clr_q;
  logic [MAX_STATES-1:0] fin_q;
  logic [SW-1:0]         i_q;
  logic [SW:0]           j_q;
  logic [AW-1:0]         a_q;
  logic                  sweep0_q;
  logic                  changed_q;
  logic [MAX_STATES-1:0] row_q;
  logic [MAX_STATES-1:0] nonleader_q;
  logic [NW-1:0]         count_q;
  logic [SW-1:0]         j_idx;

  logic                  load_ok;
  logic                  tr_we;
  logic [TAW-1:0]        tr_waddr;
  logic [TR_W-1:0]       tr_wdata;
  logic [TAW-1:0]        tra_raddr;
  logic [TAW-1:0]        trb_raddr;
  logic [TR_W-1:0]       tra_rdata;
  logic [TR_W-1:0]       trb_rdata;
  logic [SW-1:0]         d_raddr;
  logic [MAX_STATES-1:0] d_rdata;
  logic                  pi;
  logic                  pj;
  logic [TGT_W-1:0]      tgt_lo;
  logic [TGT_W-1:0]      tgt_hi;
  logic [MAX_STATES-1:0] upper_mask;

  // States and symbols in use, saturated into their legal ranges.
  always_comb begin
    if (state_count_i == 5'd0) begin
      ns = NW'(1);
    end else if (int'(state_count_i) > MAX_STATES) begin
      ns = NW'(MAX_STATES);
    end else begin
      ns = NW'(state_count_i);
    end
    if (symbol_count_i == 4'd0) begin
      nsym = YW'(1);
    end else if (int'(symbol_count_i) > MAX_SYMBOLS) begin
      nsym = YW'(MAX_SYMBOLS);
    end else begin
      nsym = YW'(symbol_count_i);
    end
  end

  assign j_idx = j_q[SW-1:0];

  // Transition table: the clearing pass after reset and the load writes share
  // the write port; two copies give one read port for each state of a pair.
  always_comb begin
    load_ok = (int'(state_index_i) < MAX_STATES) && (int'(symbol_index_i) < MAX_SYMBOLS);
    if (cmd_i.clr_step) begin
      tr_we    = 1'b1;
      tr_waddr = clr_q;
      tr_wdata = '0;
    end else begin
      tr_we    = cmd_i.load_tr && load_ok;
      tr_waddr = TAW'(state_index_i) * TAW'(MAX_SYMBOLS) + TAW'(symbol_index_i);
      tr_wdata = has_target_i ? {1'b1, target_state_i} : '0;
    end
    tra_raddr = TAW'(i_q) * TAW'(MAX_SYMBOLS) + TAW'(a_q);
    trb_raddr = TAW'(j_idx) * TAW'(MAX_SYMBOLS) + TAW'(a_q);
  end

  dfaec_ram #(
    .WIDTH (TR_W),
    .DEPTH (TDEPTH)
  ) u_tr_ram_a (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .raddr_i (tra_raddr),
    .rdata_o (tra_rdata)
  );

  dfaec_ram #(
    .WIDTH (TR_W),
    .DEPTH (TDEPTH)
  ) u_tr_ram_b (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .raddr_i (trb_raddr),
    .rdata_o (trb_rdata)
  );

  // A transition into a state outside the ones in use counts as absent.
  always_comb begin
    pi = tra_rdata[TR_W-1] && (int'(tra_rdata[TGT_W-1:0]) < int'(ns));
    pj = trb_rdata[TR_W-1] && (int'(trb_rdata[TGT_W-1:0]) < int'(ns));
    if (tra_rdata[TGT_W-1:0] < trb_rdata[TGT_W-1:0]) begin
      tgt_lo = tra_rdata[TGT_W-1:0];
      tgt_hi = trb_rdata[TGT_W-1:0];
    end else begin
      tgt_lo = trb_rdata[TGT_W-1:0];
      tgt_hi = tra_rdata[TGT_W-1:0];
    end
  end

  // The pair table keeps only the upper triangle: row of the lower state,
  // bit of the higher one.
  assign d_raddr = cmd_i.pair_rd ? SW'(tgt_lo) : i_q;

  dfaec_ram #(
    .WIDTH (MAX_STATES),
    .DEPTH (MAX_STATES)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.row_write),
    .waddr_i (i_q),
    .wdata_i (row_q),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_comb begin
    for (int b = 0; b < MAX_STATES; b++) begin
      upper_mask[b] = (b > int'(i_q)) && (b < int'(ns));
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      fin_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      a_q       <= '0;
      sweep0_q  <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + TAW'(1);
      end
      if (cmd_i.load_fin && (int'(state_index_i) < MAX_STATES)) begin
        fin_q[SW'(state_index_i)] <= final_mark_i;
      end
      if (cmd_i.comp_start || cmd_i.sweep_next || cmd_i.cnt_start || cmd_i.tally_start) begin
        i_q <= '0;
      end else if (cmd_i.i_next) begin
        i_q <= i_q + SW'(1);
      end
      if (cmd_i.row_capture) begin
        j_q <= (SW+1)'(i_q) + (SW+1)'(1);
      end else if (cmd_i.j_next || cmd_i.mark) begin
        j_q <= j_q + (SW+1)'(1);
      end
      if (cmd_i.a_clear) begin
        a_q <= '0;
      end else if (cmd_i.a_next) begin
        a_q <= a_q + AW'(1);
      end
      if (cmd_i.comp_start) begin
        sweep0_q <= 1'b1;
      end else if (cmd_i.sweep_next) begin
        sweep0_q <= 1'b0;
      end
      if (cmd_i.comp_start || cmd_i.sweep_next) begin
        changed_q <= 1'b0;
      end else if (cmd_i.mark) begin
        changed_q <= 1'b1;
      end
    end
  end

  // Working row, non-leader set and tally.
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_capture) begin
      row_q <= sweep0_q ? '0 : d_rdata;
    end else if (cmd_i.mark) begin
      row_q[j_idx] <= 1'b1;
    end
    if (cmd_i.cnt_start) begin
      nonleader_q <= '0;
    end else if (cmd_i.cnt_acc) begin
      nonleader_q <= nonleader_q | (~d_rdata & upper_mask);
    end
    if (cmd_i.tally_start) begin
      count_q <= '0;
    end else if (cmd_i.tally) begin
      count_q <= count_q + NW'(!nonleader_q[i_q]);
    end
  end

  always_comb begin
    sts_o.clr_last  = (int'(clr_q) == TDEPTH - 1);
    sts_o.j_end     = (int'(j_q) >= int'(ns));
    sts_o.row_bit   = row_q[j_idx];
    // The initial sweep marks pairs that differ in finality or in the
    // presence of a transition on the current symbol.
    sts_o.ev_hit    = sweep0_q && ((fin_q[i_q] != fin_q[j_idx]) || (pi != pj));
    sts_o.ev_need_d = !sweep0_q && pi && pj && (tra_rdata[TGT_W-1:0] != trb_rdata[TGT_W-1:0]);
    sts_o.d_hit     = d_rdata[SW'(tgt_hi)];
    sts_o.a_last    = (int'(a_q) == int'(nsym) - 1);
    sts_o.i_last    = (int'(i_q) == int'(ns) - 1);
    sts_o.again     = sweep0_q || changed_q;
  end

  assign class_count_o = (int'(count_q) > CLASS_MAX) ? 5'(CLASS_MAX) : 5'(count_q);

  // A pair is only marked once, and only while it is a real pair above the
  // diagonal of the states in use.
  a_mark_fresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> (!row_q[j_idx] && (int'(j_q) > int'(i_q)) && (int'(j_q) < int'(ns))))
    else $error("pair marked twice or outside the upper triangle");

  a_row_in_use : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_write |-> (int'(i_q) < int'(ns)))
    else $error("pair row written beyond the states in use");

endmodule

// File: rtl/core/dfaec_ctrl.sv
// ----------------------------------------------------------------------------
// DFA equivalent-state counter controller
// Sequences the clearing pass, the load words and the table filling sweeps,
// then the class tally, by commands to the datapath.
// ----------------------------------------------------------------------------
module dfaec_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic [1:0]            op_i,
  input  dfaec_pkg::dfaec_sts_t sts_i,
  output dfaec_pkg::dfaec_cmd_t cmd_o,
  output logic                  busy,
  output logic                  done_o
);
  import dfaec_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ROW_LOAD = 4'd2;
  localparam logic [3:0] S_ROW_WAIT = 4'd3;
  localparam logic [3:0] S_PAIR     = 4'd4;
  localparam logic [3:0] S_SYM_RD   = 4'd5;
  localparam logic [3:0] S_SYM_EV   = 4'd6;
  localparam logic [3:0] S_SYM_D    = 4'd7;
  localparam logic [3:0] S_ROW_END  = 4'd8;
  localparam logic [3:0] S_CNT_RD   = 4'd9;
  localparam logic [3:0] S_CNT_ACC  = 4'd10;
  localparam logic [3:0] S_TALLY    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (op_i)
            OP_FINAL: cmd_o.load_fin = 1'b1;
            OP_TRANS: cmd_o.load_tr  = 1'b1;
            OP_COUNT: begin
              cmd_o.comp_start = 1'b1;
              state_d          = S_ROW_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_ROW_LOAD: state_d = S_ROW_WAIT;
      S_ROW_WAIT: begin
        cmd_o.row_capture = 1'b1;
        state_d           = S_PAIR;
      end
      S_PAIR: begin
        if (sts_i.j_end) begin
          state_d = S_ROW_END;
        end else if (sts_i.row_bit) begin
          cmd_o.j_next = 1'b1;
        end else begin
          cmd_o.a_clear = 1'b1;
          state_d       = S_SYM_RD;
        end
      end
      S_SYM_RD: state_d = S_SYM_EV;
      S_SYM_EV: begin
        cmd_o.pair_rd = 1'b1;
        if (sts_i.ev_hit) begin
          cmd_o.mark = 1'b1;
          state_d    = S_PAIR;
        end else if (sts_i.ev_need_d) begin
          state_d = S_SYM_D;
        end else if (sts_i.a_last) begin
          cmd_o.j_next = 1'b1;
          state_d      = S_PAIR;
        end else begin
          cmd_o.a_next = 1'b1;
          state_d      = S_SYM_RD;
        end
      end
      S_SYM_D: begin
        cmd_o.pair_rd = 1'b1;
        if (sts_i.d_hit) begin
          cmd_o.mark = 1'b1;
          state_d    = S_PAIR;
        end else if (sts_i.a_last) begin
          cmd_o.j_next = 1'b1;
          state_d      = S_PAIR;
        end else begin
          cmd_o.a_next = 1'b1;
          state_d      = S_SYM_RD;
        end
      end
      S_ROW_END: begin
        cmd_o.row_write = 1'b1;
        if (!sts_i.i_last) begin
          cmd_o.i_next = 1'b1;
          state_d      = S_ROW_LOAD;
        end else if (sts_i.again) begin
          // Sweep again until a whole sweep marks nothing new.
          cmd_o.sweep_next = 1'b1;
          state_d          = S_ROW_LOAD;
        end else begin
          cmd_o.cnt_start = 1'b1;
          state_d         = S_CNT_RD;
        end
      end
      S_CNT_RD: state_d = S_CNT_ACC;
      S_CNT_ACC: begin
        cmd_o.cnt_acc = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.tally_start = 1'b1;
          state_d           = S_TALLY;
        end else begin
          cmd_o.i_next = 1'b1;
          state_d      = S_CNT_RD;
        end
      end
      S_TALLY: begin
        cmd_o.tally = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.i_next = 1'b1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after delivering a word");

  a_count_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_COUNT)) |=> (busy && !done_o))
    else $error("count command did not start a computation");

endmodule
